// ===== sv/rgb_fade_pwm_with_blink_core_macros.svh =====
// Assertion macros used by the top RTL file of the LED fade block.
`ifndef RGB_FADE_PWM_WITH_BLINK_CORE_MACROS_SVH
`define RGB_FADE_PWM_WITH_BLINK_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RFPB_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rfpb assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RFPB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rfpb assertion failed");

`endif

// ===== sv/rfpb_pkg.sv =====
package rfpb_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FADE_INTERVAL  = 3'd0,
        CFG_PWM_PERIOD     = 3'd1,
        CFG_BLINK_INTERVAL = 3'd2,
        CFG_CYCLE_STEPS    = 3'd3,
        CFG_RED_MAX        = 3'd4,
        CFG_GREEN_START    = 3'd5,
        CFG_BLUE_MAX       = 3'd6
    } cfg_idx_t;

    localparam logic [15:0] FADE_INTERVAL_RST  = 16'd300;
    localparam logic [7:0]  PWM_PERIOD_RST     = 8'd20;
    localparam logic [7:0]  BLINK_INTERVAL_RST = 8'd250;
    localparam logic [7:0]  CYCLE_STEPS_RST    = 8'd20;
    localparam logic [7:0]  RED_MAX_RST        = 8'd10;
    localparam logic [7:0]  GREEN_START_RST    = 8'd10;
    localparam logic [7:0]  BLUE_MAX_RST       = 8'd5;
    localparam logic [7:0]  GREEN_DUTY_RST     = 8'd10;

    typedef struct packed {
        logic [15:0] fade_interval;
        logic [7:0]  pwm_period;
        logic [7:0]  blink_interval;
        logic [7:0]  cycle_steps;
        logic [7:0]  red_max;
        logic [7:0]  green_start;
        logic [7:0]  blue_max;
    } cfg_t;

    typedef struct packed {
        logic rgb_red;
        logic rgb_green;
        logic rgb_blue;
        logic green_led;
        logic yellow_led;
    } res_t;

endpackage

// ===== sv/rgb_fade_pwm_with_blink_core.sv =====
// Channel | Direction | Ports
// input   | in        | s_valid, s_ready, s_key_pressed
// result  | out       | m_valid, m_ready, m_rgb_red .. m_yellow_led
// config  | in        | cfg_valid, cfg_ready, cfg_index, cfg_data
// One tick is taken every cycle while s_ready is high; each result is registered.
// The state update for a tick is combinational between the input and result registers.
// Synchronous active-low reset restores counters, duties, LEDs, config, valid flags.
// A stalled result register holds the input register, which then holds s_ready low.
// Configuration writes are always accepted and take effect on the next cycle.
`include "rgb_fade_pwm_with_blink_core_macros.svh"

module rgb_fade_pwm_with_blink_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_key_pressed,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_rgb_red,
    output logic                            m_rgb_green,
    output logic                            m_rgb_blue,
    output logic                            m_green_led,
    output logic                            m_yellow_led,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rfpb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rfpb_pkg::CFG_DATA_W-1:0] cfg_data
);

    rfpb_pkg::cfg_t cfg;
    rfpb_pkg::res_t res;
    rfpb_pkg::res_t res_reg;
    logic           in_vld_reg;
    logic           key_reg;
    logic           out_vld_reg;
    logic           adv;

    assign cfg_ready = 1'b1;
    assign adv       = !out_vld_reg || m_ready;
    assign s_ready   = !in_vld_reg || adv;

    rfpb_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    rfpb_eval u_eval (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv && in_vld_reg),
        .key     (key_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (adv) begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            key_reg <= s_key_pressed;
        end
        if (adv && in_vld_reg) begin
            res_reg <= res;
        end
    end

    assign m_valid      = out_vld_reg;
    assign m_rgb_red    = res_reg.rgb_red;
    assign m_rgb_green  = res_reg.rgb_green;
    assign m_rgb_blue   = res_reg.rgb_blue;
    assign m_green_led  = res_reg.green_led;
    assign m_yellow_led = res_reg.yellow_led;

    `RFPB_ASSERT_NOW(a_stall_blocks_input, aclk, aresetn,
        in_vld_reg && out_vld_reg && !m_ready, !s_ready)
    `RFPB_ASSERT_NEXT(a_held_tick_stays, aclk, aresetn,
        in_vld_reg && !adv, in_vld_reg && $stable(key_reg))
    `RFPB_ASSERT_NOW(a_leds_opposite, aclk, aresetn,
        out_vld_reg, res_reg.green_led != res_reg.yellow_led)
    `RFPB_ASSERT_NEXT(a_result_follows_tick, aclk, aresetn,
        in_vld_reg && adv, out_vld_reg)

endmodule

// ===== sv/rfpb_cfg.sv =====
module rfpb_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            wr_en,
    input  logic [rfpb_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [rfpb_pkg::CFG_DATA_W-1:0] wr_data,
    output rfpb_pkg::cfg_t                  cfg
);

    rfpb_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fade_interval  <= rfpb_pkg::FADE_INTERVAL_RST;
            cfg_reg.pwm_period     <= rfpb_pkg::PWM_PERIOD_RST;
            cfg_reg.blink_interval <= rfpb_pkg::BLINK_INTERVAL_RST;
            cfg_reg.cycle_steps    <= rfpb_pkg::CYCLE_STEPS_RST;
            cfg_reg.red_max        <= rfpb_pkg::RED_MAX_RST;
            cfg_reg.green_start    <= rfpb_pkg::GREEN_START_RST;
            cfg_reg.blue_max       <= rfpb_pkg::BLUE_MAX_RST;
        end else if (wr_en) begin
            unique case (rfpb_pkg::cfg_idx_t'(wr_index))
                rfpb_pkg::CFG_FADE_INTERVAL:  cfg_reg.fade_interval  <= wr_data;
                rfpb_pkg::CFG_PWM_PERIOD:     cfg_reg.pwm_period     <= wr_data[7:0];
                rfpb_pkg::CFG_BLINK_INTERVAL: cfg_reg.blink_interval <= wr_data[7:0];
                rfpb_pkg::CFG_CYCLE_STEPS:    cfg_reg.cycle_steps    <= wr_data[7:0];
                rfpb_pkg::CFG_RED_MAX:        cfg_reg.red_max        <= wr_data[7:0];
                rfpb_pkg::CFG_GREEN_START:    cfg_reg.green_start    <= wr_data[7:0];
                rfpb_pkg::CFG_BLUE_MAX:       cfg_reg.blue_max       <= wr_data[7:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/rfpb_eval.sv =====
module rfpb_eval (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           key,
    input  rfpb_pkg::cfg_t cfg,
    output rfpb_pkg::res_t res
);

    logic [15:0] tick_reg,  tick_next;
    logic [7:0]  phase_reg, phase_next;
    logic [7:0]  blink_reg, blink_next;
    logic [7:0]  red_reg,   red_next;
    logic [7:0]  green_reg, green_next;
    logic [7:0]  blue_reg,  blue_next;
    logic [7:0]  step_reg,  step_next;
    logic        gled_reg,  gled_next;
    logic        yled_reg,  yled_next;

    logic [15:0] tick_inc;
    logic [7:0]  phase_inc, phase_mid, blink_inc;
    logic [7:0]  red_inc, green_dec, blue_inc, step_inc;
    logic        fade;

    always_comb begin
        tick_inc  = tick_reg + 16'd1;
        phase_inc = phase_reg + 8'd1;
        blink_inc = blink_reg + 8'd1;
        red_inc   = red_reg + 8'd1;
        green_dec = green_reg - 8'd1;
        blue_inc  = blue_reg + 8'd1;
        step_inc  = step_reg + 8'd1;
        fade      = (tick_inc == cfg.fade_interval);

        tick_next  = tick_inc;
        phase_mid  = phase_inc;
        red_next   = red_reg;
        green_next = green_reg;
        blue_next  = blue_reg;
        step_next  = step_reg;

        if (fade) begin
            tick_next  = 16'd0;
            phase_mid  = 8'd0;
            red_next   = (red_inc > cfg.red_max) ? 8'd0 : red_inc;
            green_next = (green_dec > cfg.green_start) ? 8'd0 : green_dec;
            blue_next  = (blue_inc > cfg.blue_max) ? 8'd0 : blue_inc;
            step_next  = step_inc;
            if (step_inc == cfg.cycle_steps) begin
                step_next  = 8'd0;
                red_next   = 8'd0;
                green_next = cfg.green_start;
                blue_next  = 8'd0;
            end
        end

        phase_next = (phase_mid == cfg.pwm_period) ? 8'd0 : phase_mid;

        blink_next = blink_inc;
        gled_next  = gled_reg;
        yled_next  = yled_reg;
        if (!key && (blink_inc == cfg.blink_interval)) begin
            blink_next = 8'd0;
            gled_next  = ~gled_reg;
            yled_next  = ~yled_reg;
        end

        res.rgb_red    = key && (phase_next != 8'd0) && (phase_next <= red_next);
        res.rgb_green  = key && (phase_next != 8'd0) && (phase_next <= green_next);
        res.rgb_blue   = key && (phase_next != 8'd0) && (phase_next <= blue_next);
        res.green_led  = gled_next;
        res.yellow_led = yled_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg  <= 16'd0;
            phase_reg <= 8'd0;
            blink_reg <= 8'd0;
            red_reg   <= 8'd0;
            green_reg <= rfpb_pkg::GREEN_DUTY_RST;
            blue_reg  <= 8'd0;
            step_reg  <= 8'd0;
            gled_reg  <= 1'b1;
            yled_reg  <= 1'b0;
        end else if (en) begin
            tick_reg  <= tick_next;
            phase_reg <= phase_next;
            blink_reg <= blink_next;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            step_reg  <= step_next;
            gled_reg  <= gled_next;
            yled_reg  <= yled_next;
        end
    end

endmodule

// ===== dv/rgb_fade_pwm_with_blink_core_chk.sv =====
module rgb_fade_pwm_with_blink_core_chk (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic                            s_key_pressed,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic                            m_rgb_red,
    input  logic                            m_rgb_green,
    input  logic                            m_rgb_blue,
    input  logic                            m_green_led,
    input  logic                            m_yellow_led,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [rfpb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rfpb_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              fail_count,
    output int                              led_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    rfpb_pkg::cfg_t regs;
    logic [15:0]    tick_cnt;
    logic [7:0]     phase;
    logic [7:0]     blink_cnt;
    logic [7:0]     red_duty;
    logic [7:0]     grn_duty;
    logic [7:0]     blu_duty;
    logic [7:0]     step_cnt;
    logic           grn_led;
    logic           yel_led;
    rfpb_pkg::res_t led_expect_q[$];
    int             err_cnt;

    initial begin
        fail_count  = 0;
        led_pending = 0;
        err_cnt     = 0;
    end

    function automatic rfpb_pkg::res_t next_led_outputs(logic key);
        rfpb_pkg::res_t r;
        r = '0;
        tick_cnt  = tick_cnt + 16'd1;
        phase     = phase + 8'd1;
        blink_cnt = blink_cnt + 8'd1;
        if (tick_cnt == regs.fade_interval) begin
            tick_cnt = '0;
            phase    = '0;
            red_duty = red_duty + 8'd1;
            if (red_duty > regs.red_max) red_duty = '0;
            grn_duty = grn_duty - 8'd1;
            if (grn_duty > regs.green_start) grn_duty = '0;
            blu_duty = blu_duty + 8'd1;
            if (blu_duty > regs.blue_max) blu_duty = '0;
            step_cnt = step_cnt + 8'd1;
            if (step_cnt == regs.cycle_steps) begin
                step_cnt = '0;
                red_duty = '0;
                grn_duty = regs.green_start;
                blu_duty = '0;
            end
        end
        if (phase == regs.pwm_period) phase = '0;
        if (key) begin
            if (phase != 8'd0) begin
                r.rgb_red   = (phase <= red_duty);
                r.rgb_green = (phase <= grn_duty);
                r.rgb_blue  = (phase <= blu_duty);
            end
        end else if (blink_cnt == regs.blink_interval) begin
            grn_led   = ~grn_led;
            yel_led   = ~yel_led;
            blink_cnt = '0;
        end
        r.green_led  = grn_led;
        r.yellow_led = yel_led;
        return r;
    endfunction

    task automatic check_field(input string name, input logic exp_v, input logic act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0b, got %0b", name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    always @(posedge aclk) begin
        rfpb_pkg::res_t exp_r;
        rfpb_pkg::res_t act_r;
        if (!aresetn) begin
            regs.fade_interval  = rfpb_pkg::FADE_INTERVAL_RST;
            regs.pwm_period     = rfpb_pkg::PWM_PERIOD_RST;
            regs.blink_interval = rfpb_pkg::BLINK_INTERVAL_RST;
            regs.cycle_steps    = rfpb_pkg::CYCLE_STEPS_RST;
            regs.red_max        = rfpb_pkg::RED_MAX_RST;
            regs.green_start    = rfpb_pkg::GREEN_START_RST;
            regs.blue_max       = rfpb_pkg::BLUE_MAX_RST;
            tick_cnt  = '0;
            phase     = '0;
            blink_cnt = '0;
            red_duty  = '0;
            grn_duty  = rfpb_pkg::GREEN_DUTY_RST;
            blu_duty  = '0;
            step_cnt  = '0;
            grn_led   = 1'b1;
            yel_led   = 1'b0;
            led_expect_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (rfpb_pkg::cfg_idx_t'(cfg_index))
                    rfpb_pkg::CFG_FADE_INTERVAL:  regs.fade_interval  = cfg_data;
                    rfpb_pkg::CFG_PWM_PERIOD:     regs.pwm_period     = cfg_data[7:0];
                    rfpb_pkg::CFG_BLINK_INTERVAL: regs.blink_interval = cfg_data[7:0];
                    rfpb_pkg::CFG_CYCLE_STEPS:    regs.cycle_steps    = cfg_data[7:0];
                    rfpb_pkg::CFG_RED_MAX:        regs.red_max        = cfg_data[7:0];
                    rfpb_pkg::CFG_GREEN_START:    regs.green_start    = cfg_data[7:0];
                    rfpb_pkg::CFG_BLUE_MAX:       regs.blue_max       = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (led_expect_q.size() == 0) begin
                    $error("result transfer with no tick outstanding");
                    err_cnt++;
                end else begin
                    exp_r = led_expect_q.pop_front();
                    act_r = {m_rgb_red, m_rgb_green, m_rgb_blue, m_green_led, m_yellow_led};
                    check_field("rgb_red", exp_r.rgb_red, act_r.rgb_red);
                    check_field("rgb_green", exp_r.rgb_green, act_r.rgb_green);
                    check_field("rgb_blue", exp_r.rgb_blue, act_r.rgb_blue);
                    check_field("green_led", exp_r.green_led, act_r.green_led);
                    check_field("yellow_led", exp_r.yellow_led, act_r.yellow_led);
                end
            end
            if (s_valid && s_ready) begin
                led_expect_q.push_back(next_led_outputs(s_key_pressed));
            end
        end
        fail_count  <= err_cnt;
        led_pending <= led_expect_q.size();
    end

endmodule

// ===== dv/rgb_fade_pwm_with_blink_core_tb.sv =====
module rgb_fade_pwm_with_blink_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_OFF    = 300;

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    logic                            s_key_pressed;
    logic                            m_valid;
    logic                            m_ready;
    logic                            m_rgb_red;
    logic                            m_rgb_green;
    logic                            m_rgb_blue;
    logic                            m_green_led;
    logic                            m_yellow_led;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [rfpb_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [rfpb_pkg::CFG_DATA_W-1:0] cfg_data;
    int                              fail_count;
    int                              led_pending;
    int                              quiet_cycles;

    always #5 aclk = ~aclk;

    rgb_fade_pwm_with_blink_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_key_pressed (s_key_pressed),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_rgb_red     (m_rgb_red),
        .m_rgb_green   (m_rgb_green),
        .m_rgb_blue    (m_rgb_blue),
        .m_green_led   (m_green_led),
        .m_yellow_led  (m_yellow_led),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    rgb_fade_pwm_with_blink_core_chk i_chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_key_pressed (s_key_pressed),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_rgb_red     (m_rgb_red),
        .m_rgb_green   (m_rgb_green),
        .m_rgb_blue    (m_rgb_blue),
        .m_green_led   (m_green_led),
        .m_yellow_led  (m_yellow_led),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .led_pending   (led_pending)
    );

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // The receiver first holds off long enough for the block to back up into its input.
    initial begin
        int mode;
        int span;
        int n;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        repeat (40) @(posedge aclk);
        repeat (HOLD_OFF) @(posedge aclk);
        n = 0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            repeat (span) begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 7) != 0);
                    default: m_ready <= ((n % 5) < 3);
                endcase
                n++;
                @(posedge aclk);
            end
        end
    end

    task automatic push_tick(input logic key);
        s_valid       <= 1'b1;
        s_key_pressed <= key;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic run_ticks(input int count, input bit bursty);
        int burst;
        int gap;
        int run;
        logic key;
        burst = $urandom_range(1, 30);
        run   = 0;
        key   = 1'b0;
        for (int i = 0; i < count; i++) begin
            if (run == 0) begin
                key = 1'($urandom_range(0, 1));
                run = $urandom_range(1, 40);
            end
            run--;
            if (bursty && burst <= 0) begin
                gap   = $urandom_range(0, 6);
                burst = $urandom_range(1, 30);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            burst--;
            push_tick(key);
        end
    endtask

    task automatic run_pattern(input logic [11:0] keys);
        for (int i = 0; i < 12; i++) begin
            push_tick(keys[i]);
        end
    endtask

    task automatic wait_idle();
        @(posedge aclk);
        while (led_pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input rfpb_pkg::cfg_idx_t idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic program_regs(input rfpb_pkg::cfg_t c);
        write_reg(rfpb_pkg::CFG_FADE_INTERVAL, c.fade_interval);
        write_reg(rfpb_pkg::CFG_PWM_PERIOD, {8'($urandom), c.pwm_period});
        write_reg(rfpb_pkg::CFG_BLINK_INTERVAL, {8'($urandom), c.blink_interval});
        write_reg(rfpb_pkg::CFG_CYCLE_STEPS, {8'($urandom), c.cycle_steps});
        write_reg(rfpb_pkg::CFG_RED_MAX, {8'($urandom), c.red_max});
        write_reg(rfpb_pkg::CFG_GREEN_START, {8'($urandom), c.green_start});
        write_reg(rfpb_pkg::CFG_BLUE_MAX, {8'($urandom), c.blue_max});
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick8(input int lo, input int hi);
        if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 3))
                0: return 8'd0;
                1: return 8'd1;
                2: return 8'd254;
                default: return 8'd255;
            endcase
        end
        return 8'($urandom_range(lo, hi));
    endfunction

    function automatic rfpb_pkg::cfg_t pick_setting(input int mode);
        rfpb_pkg::cfg_t c;
        case (mode)
            0: c = '{16'd1, 8'd1, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0};
            1: c = '{16'd65535, 8'd255, 8'd255, 8'd255, 8'd254, 8'd254, 8'd254};
            default: begin
                if ($urandom_range(0, 5) == 0) begin
                    case ($urandom_range(0, 3))
                        0: c.fade_interval = 16'd0;
                        1: c.fade_interval = 16'd1;
                        2: c.fade_interval = 16'd65534;
                        default: c.fade_interval = 16'd65535;
                    endcase
                end else begin
                    c.fade_interval = 16'($urandom_range(1, 40));
                end
                c.pwm_period     = pick8(1, 16);
                c.blink_interval = pick8(1, 20);
                c.cycle_steps    = pick8(1, 8);
                c.red_max        = pick8(0, 16);
                c.green_start    = pick8(0, 16);
                c.blue_max       = pick8(0, 16);
            end
        endcase
        return c;
    endfunction

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_key_pressed = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        quiet_cycles  = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        run_ticks(150, 1'b1);
        s_valid <= 1'b0;

        wait_idle();
        program_regs('{16'd3, 8'd4, 8'd2, 8'd2, 8'd254, 8'd255, 8'd0});
        run_pattern(12'b1100_1011_0110);
        s_valid <= 1'b0;

        wait_idle();
        program_regs('{16'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255});
        run_pattern(12'b0011_0100_1001);
        s_valid <= 1'b0;

        for (int p = 0; p < 9; p++) begin
            wait_idle();
            program_regs(pick_setting(p));
            run_ticks($urandom_range(100, 180), $urandom_range(0, 3) != 0);
            s_valid <= 1'b0;
        end

        wait_idle();
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/rfpb_pkg.sv
sv/rfpb_cfg.sv
sv/rfpb_eval.sv
sv/rgb_fade_pwm_with_blink_core.sv
dv/rgb_fade_pwm_with_blink_core_chk.sv
dv/rgb_fade_pwm_with_blink_core_tb.sv
